// ===== hw/rtl/cmbx_pkg.sv =====
// Package for the coprocessor mailbox: command codes, register offsets, the
// item type passed from the front end through the queue to the back end, and
// the result type of the back end. No dependencies.
package cmbx_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_PUSH  = 2'd2;

    localparam logic [19:0] ADDR_CONTROL = 20'h00044;
    localparam logic [19:0] ADDR_STATUS  = 20'h00048;
    localparam logic [11:0] OFS_OUT_CTRL = 12'h110;
    localparam logic [11:0] OFS_IN_CTRL  = 12'h114;
    localparam logic [11:0] OFS_STAGED   = 12'h800;
    localparam logic [11:0] OFS_SEND     = 12'h808;
    localparam logic [11:0] OFS_HEAD_PL  = 12'h830;
    localparam logic [11:0] OFS_HEAD_EP  = 12'h838;
    localparam logic [31:0] CTRL_MASK    = 32'h00F30000;
    localparam int          TYPE_SHIFT   = 52;

    // Management message types.
    localparam logic [7:0] MT_HELLO     = 8'h01;
    localparam logic [7:0] MT_HELLO_ACK = 8'h02;
    localparam logic [7:0] MT_PING      = 8'h03;
    localparam logic [7:0] MT_PONG      = 8'h04;
    localparam logic [7:0] MT_EP_CTRL   = 8'h05;
    localparam logic [7:0] MT_PWR_REQ   = 8'h06;
    localparam logic [7:0] MT_PWR_ACK   = 8'h07;
    localparam logic [7:0] MT_MAP       = 8'h08;
    localparam logic [7:0] MT_HOST_PWR  = 8'h0B;

    localparam logic [1:0] HS_IDLE     = 2'd0;
    localparam logic [1:0] HS_WAIT_ACK = 2'd1;
    localparam logic [1:0] HS_WAIT_MAP = 2'd2;
    localparam logic [1:0] HS_BOOTED   = 2'd3;

    // Classified operation handed from the front end to the back end.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_RD_CTRL  = 4'd1;
    localparam logic [3:0] OP_RD_STAT  = 4'd2;
    localparam logic [3:0] OP_RD_OUTC  = 4'd3;
    localparam logic [3:0] OP_RD_INC   = 4'd4;
    localparam logic [3:0] OP_RD_HPL   = 4'd5;
    localparam logic [3:0] OP_RD_HEP   = 4'd6;
    localparam logic [3:0] OP_RD_STG   = 4'd7;
    localparam logic [3:0] OP_WR_CTRL  = 4'd8;
    localparam logic [3:0] OP_WR_OUTC  = 4'd9;
    localparam logic [3:0] OP_WR_INC   = 4'd10;
    localparam logic [3:0] OP_WR_STG   = 4'd11;
    localparam logic [3:0] OP_SEND     = 4'd12;
    localparam logic [3:0] OP_PUSH     = 4'd13;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] data;
        logic [7:0]  endpoint;
    } op_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        irq_inbox_not_empty;
        logic        irq_inbox_empty;
        logic        overflow_dropped;
        logic        message_unhandled;
    } res_t;

endpackage

// ===== hw/rtl/cmbx_if.sv =====
// Valid/ready channel interfaces for the mailbox items and results.
// No dependencies.
interface cmbx_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [19:0] address;
    logic [63:0] write_data;
    logic [7:0]  endpoint;
    modport source (output valid, cmd, address, write_data, endpoint, input ready);
    modport sink (input valid, cmd, address, write_data, endpoint, output ready);
endinterface

interface cmbx_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic        irq_inbox_not_empty;
    logic        irq_inbox_empty;
    logic        overflow_dropped;
    logic        message_unhandled;
    modport source (output valid, read_data, irq_inbox_not_empty, irq_inbox_empty,
                    overflow_dropped, message_unhandled, input ready);
    modport sink (input valid, read_data, irq_inbox_not_empty, irq_inbox_empty,
                  overflow_dropped, message_unhandled, output ready);
endinterface

// ===== hw/rtl/cmbx_front.sv =====
// Front end: accepts a transaction, decodes its address and registers the
// classified operation. Depends on cmbx_pkg.
module cmbx_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       cmd,
    input  logic [19:0]      address,
    input  logic [63:0]      write_data,
    input  logic [7:0]       endpoint,
    input  logic [19:0]      base,
    output logic             op_valid,
    input  logic             op_ready,
    output cmbx_pkg::op_t    op
);
    import cmbx_pkg::*;

    logic        valid_reg;
    op_t         op_reg;
    op_t         op_next;
    logic        in_win;
    logic [19:0] rel;

    assign rel    = address - base;
    assign in_win = ({1'b0, address} >= {1'b0, base}) &&
                    ({1'b0, address} < {1'b0, base} + 21'h01000);

    always_comb
    begin
        op_next.op       = OP_NONE;
        op_next.data     = write_data;
        op_next.endpoint = endpoint;
        if (cmd == CMD_PUSH)
        begin
            op_next.op = OP_PUSH;
        end
        else if (cmd == CMD_READ)
        begin
            if (address == ADDR_CONTROL)
                op_next.op = OP_RD_CTRL;
            else if (address == ADDR_STATUS)
                op_next.op = OP_RD_STAT;
            else if (in_win)
            begin
                case (rel[11:0])
                    OFS_OUT_CTRL: op_next.op = OP_RD_OUTC;
                    OFS_IN_CTRL:  op_next.op = OP_RD_INC;
                    OFS_HEAD_PL:  op_next.op = OP_RD_HPL;
                    OFS_HEAD_EP:  op_next.op = OP_RD_HEP;
                    OFS_STAGED:   op_next.op = OP_RD_STG;
                    default:      op_next.op = OP_NONE;
                endcase
            end
        end
        else if (cmd == CMD_WRITE)
        begin
            if (address == ADDR_CONTROL)
                op_next.op = OP_WR_CTRL;
            else if (address == ADDR_STATUS)
                op_next.op = OP_NONE;
            else if (in_win)
            begin
                case (rel[11:0])
                    OFS_OUT_CTRL: op_next.op = OP_WR_OUTC;
                    OFS_IN_CTRL:  op_next.op = OP_WR_INC;
                    OFS_STAGED:   op_next.op = OP_WR_STG;
                    OFS_SEND:     op_next.op = OP_SEND;
                    default:      op_next.op = OP_NONE;
                endcase
            end
        end
    end

    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            op_reg <= op_next;
    end
endmodule

// ===== hw/rtl/cmbx_queue.sv =====
// Short queue between the front end and the back end.
// Depends on cmbx_pkg.
module cmbx_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  cmbx_pkg::op_t wr_op,
    output logic          rd_valid,
    input  logic          rd_ready,
    output cmbx_pkg::op_t rd_op
);
    import cmbx_pkg::*;

    op_t        slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_op    = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_op;
    end
endmodule

// ===== hw/rtl/cmbx_back.sv =====
// Back end: register file, inbound message FIFO and the endpoint-0 management
// responder, with a registered result output. Depends on cmbx_pkg.
module cmbx_back #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  cmbx_pkg::op_t  op,
    input  logic [63:0]    map01,
    input  logic [63:0]    map23,
    input  logic [63:0]    map45,
    input  logic [63:0]    map67,
    output logic           res_valid,
    input  logic           res_ready,
    output cmbx_pkg::res_t res
);
    import cmbx_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [63:0]   HELLO_MSG = {4'd0, MT_HELLO, 52'h00000_000C_000B};

    // Sequencer states.
    localparam logic [1:0] ST_EXEC = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    st_reg;
    op_t           cur_reg;
    logic [31:0]   ctrl_reg;
    logic [2:0]    status_reg;
    logic [31:0]   outc_reg;
    logic [31:0]   inc_reg;
    logic [63:0]   staged_reg;
    logic [63:0]   fpl_mem [FIFO_DEPTH];
    logic [7:0]    fep_mem [FIFO_DEPTH];
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [1:0]    hs_reg;
    logic [15:0]   ver_reg;
    logic [3:0]    nblk_reg;
    logic          pwr_pend_reg;
    logic [15:0]   cpwr_reg;
    logic [15:0]   hpwr_reg;
    logic [255:0]  running_reg;
    logic          pend_reg;
    logic [63:0]   pmsg_reg;
    logic [7:0]    pep_reg;
    logic [63:0]   rd_reg;
    logic          unh_reg;
    logic          rvalid_reg;
    res_t          res_reg;

    logic [31:0]   blk [8];
    logic [7:0]    nz;
    logic [2:0]    last_b;
    logic [2:0]    start_b;
    logic [2:0]    pick_b;
    logic [63:0]   map_body;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic [7:0]    mtype;
    logic [15:0]   mst;
    logic          boot_now;
    logic          done_fire;
    op_t           exec_op;

    assign blk[0] = map01[31:0];
    assign blk[1] = map01[63:32];
    assign blk[2] = map23[31:0];
    assign blk[3] = map23[63:32];
    assign blk[4] = map45[31:0];
    assign blk[5] = map45[63:32];
    assign blk[6] = map67[31:0];
    assign blk[7] = map67[63:32];

    // Map block search over the eight blocks. A hello acknowledgment restarts
    // the paging from block 0.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            nz[i] = blk[i] != 32'd0;
        last_b = 3'd0;
        for (int i = 1; i < 8; i++)
            if (nz[i])
                last_b = 3'(i);
        start_b = (mtype == MT_HELLO_ACK) ? 3'd0 :
                  ((nblk_reg > 4'd7) ? 3'd7 : nblk_reg[2:0]);
        pick_b  = last_b;
        if (start_b >= last_b)
            pick_b = start_b;
        else
            for (int i = 7; i >= 0; i--)
                if (3'(i) >= start_b && 3'(i) < last_b && nz[i])
                    pick_b = 3'(i);
        map_body = {29'd0, pick_b, blk[pick_b]};
        if (pick_b >= last_b)
            map_body[51] = 1'b1;
    end

    // A send takes the staged payload; a foreign-endpoint send just flags unhandled.
    always_comb
    begin
        exec_op = op;
        if (op.op == OP_SEND)
        begin
            exec_op.data = staged_reg;
            if (op.data[7:0] != 8'd0)
                exec_op.op = OP_NONE;
        end
    end

    assign boot_now = op.op == OP_WR_CTRL && op.data[4] && !ctrl_reg[4] && hs_reg == HS_IDLE;

    assign tail_sum  = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign tail      = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
    assign mtype     = cur_reg.data[59:52];
    assign mst       = cur_reg.data[15:0];
    assign done_fire = st_reg == ST_DONE && (!rvalid_reg || res_ready);

    assign op_ready  = st_reg == ST_EXEC && (!rvalid_reg || res_ready);
    assign res_valid = rvalid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_EXEC;
            ctrl_reg     <= '0;
            status_reg   <= 3'd2;
            outc_reg     <= '0;
            inc_reg      <= '0;
            staged_reg   <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            hs_reg       <= HS_IDLE;
            ver_reg      <= '0;
            nblk_reg     <= '0;
            pwr_pend_reg <= 1'b0;
            cpwr_reg     <= '0;
            hpwr_reg     <= '0;
            running_reg  <= '0;
            pend_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            if (done_fire)
                rvalid_reg <= 1'b1;
            else if (res_ready)
                rvalid_reg <= 1'b0;
            case (st_reg)
                ST_EXEC:
                begin
                    if (op_valid && op_ready)
                    begin
                        st_reg   <= ST_PUSH;
                        cur_reg  <= exec_op;
                        pend_reg <= op.op == OP_PUSH || boot_now;
                        unh_reg  <= op.op == OP_SEND && op.data[7:0] != 8'd0;
                        pep_reg  <= boot_now ? 8'd0 : op.endpoint;
                        pmsg_reg <= boot_now ? HELLO_MSG : op.data;
                        case (op.op)
                            OP_RD_CTRL: rd_reg <= {32'd0, ctrl_reg};
                            OP_RD_STAT: rd_reg <= {61'd0, status_reg};
                            OP_RD_OUTC: rd_reg <= {32'd0, outc_reg | 32'h20000};
                            OP_RD_INC:
                            begin
                                rd_reg <= {32'd0, (inc_reg & ~CTRL_MASK)
                                    | ((count_reg == '0) ? 32'h20000 : 32'h0)
                                    | ((count_reg >= DEPTH_C) ? 32'h10000 : 32'h0)
                                    | {8'd0, 4'(count_reg), 20'd0}};
                            end
                            OP_RD_HPL:
                                rd_reg <= (count_reg != '0) ? fpl_mem[head_reg] : 64'd0;
                            OP_RD_HEP:
                                rd_reg <= (count_reg != '0) ? {56'd0, fep_mem[head_reg]}
                                                            : 64'd0;
                            OP_RD_STG:  rd_reg <= staged_reg;
                            default:    rd_reg <= '0;
                        endcase
                        case (op.op)
                            OP_RD_HEP:
                                if (count_reg != '0)
                                begin
                                    head_reg  <= (head_reg == LAST_IDX) ? '0
                                                                        : head_reg + AW'(1);
                                    count_reg <= count_reg - CW'(1);
                                end
                            OP_WR_CTRL:
                            begin
                                ctrl_reg <= op.data[31:0];
                                if (boot_now)
                                begin
                                    status_reg <= 3'd1;
                                    hs_reg     <= HS_WAIT_ACK;
                                end
                                else if (!op.data[4] && ctrl_reg[4])
                                begin
                                    status_reg <= 3'd2;
                                    hs_reg     <= HS_IDLE;
                                    count_reg  <= '0;
                                end
                            end
                            OP_WR_OUTC: outc_reg   <= op.data[31:0] & ~CTRL_MASK;
                            OP_WR_INC:  inc_reg    <= op.data[31:0] & ~CTRL_MASK;
                            OP_WR_STG:  staged_reg <= op.data;
                            default:    ;
                        endcase
                    end
                end
                ST_PUSH:
                begin
                    // Management responder runs on the staged message here.
                    st_reg <= ST_DONE;
                    if (cur_reg.op == OP_SEND)
                    begin
                        pep_reg <= 8'd0;
                        case (mtype)
                            MT_HELLO_ACK:
                            begin
                                ver_reg  <= cur_reg.data[31:16];
                                hs_reg   <= HS_WAIT_MAP;
                                pend_reg <= 1'b1;
                                pmsg_reg <= {4'd0, MT_MAP, 52'd0} | map_body;
                            end
                            MT_MAP:
                            begin
                                if (cur_reg.data[51] || !cur_reg.data[0])
                                begin
                                    if (hs_reg == HS_WAIT_MAP)
                                    begin
                                        hs_reg <= HS_BOOTED;
                                        if (pwr_pend_reg)
                                        begin
                                            pwr_pend_reg <= 1'b0;
                                            cpwr_reg     <= 16'h0020;
                                            pend_reg     <= 1'b1;
                                            pmsg_reg <= {4'd0, MT_PWR_ACK, 52'h20};
                                        end
                                    end
                                end
                                else
                                begin
                                    pend_reg <= 1'b1;
                                    pmsg_reg <= {4'd0, MT_MAP, 52'd0} | map_body;
                                end
                            end
                            MT_PING:
                            begin
                                pend_reg <= 1'b1;
                                pmsg_reg <= {4'd0, MT_PONG, cur_reg.data[51:0]};
                            end
                            MT_EP_CTRL:
                                running_reg[cur_reg.data[39:32]] <=
                                    cur_reg.data[1:0] == 2'd2;
                            MT_PWR_REQ:
                            begin
                                if (mst == 16'h0220 || mst == 16'h0020)
                                begin
                                    if (hs_reg == HS_BOOTED)
                                    begin
                                        cpwr_reg <= 16'h0020;
                                        pend_reg <= 1'b1;
                                        pmsg_reg <= {4'd0, MT_PWR_ACK, 52'h20};
                                    end
                                    else
                                    begin
                                        pwr_pend_reg <= 1'b1;
                                        if (hs_reg == HS_IDLE)
                                        begin
                                            status_reg <= 3'd1;
                                            hs_reg     <= HS_WAIT_ACK;
                                            pend_reg   <= 1'b1;
                                            pmsg_reg   <= HELLO_MSG;
                                        end
                                    end
                                end
                                else
                                begin
                                    cpwr_reg <= mst;
                                    pend_reg <= 1'b1;
                                    pmsg_reg <= {4'd0, MT_PWR_ACK, 36'd0, mst};
                                end
                            end
                            MT_HOST_PWR:
                            begin
                                hpwr_reg <= mst;
                                pend_reg <= 1'b1;
                                pmsg_reg <= {4'd0, MT_HOST_PWR, 36'd0, mst};
                            end
                            default: unh_reg <= 1'b1;
                        endcase
                        if (mtype == MT_MAP || mtype == MT_HELLO_ACK)
                            nblk_reg <= (mtype == MT_MAP && (cur_reg.data[51]
                                || !cur_reg.data[0])) ? nblk_reg
                                : 4'({1'b0, map_body[34:32]} + 4'd1);
                    end
                end
                ST_DONE:
                begin
                    // FIFO write and result registration.
                    if (done_fire)
                    begin
                        st_reg <= ST_EXEC;
                        if (pend_reg && count_reg < DEPTH_C)
                            count_reg <= count_reg + CW'(1);
                        res_reg.read_data           <= rd_reg;
                        res_reg.irq_inbox_not_empty <=
                            (pend_reg && count_reg < DEPTH_C) || count_reg != '0;
                        res_reg.irq_inbox_empty     <=
                            !((pend_reg && count_reg < DEPTH_C) || count_reg != '0);
                        res_reg.overflow_dropped    <= pend_reg && count_reg >= DEPTH_C;
                        res_reg.message_unhandled   <= unh_reg;
                    end
                end
                default: st_reg <= ST_EXEC;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire && pend_reg && count_reg < DEPTH_C)
        begin
            fpl_mem[tail] <= pmsg_reg;
            fep_mem[tail] <= pep_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C) else $error("FIFO count above depth");
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && res_reg.overflow_dropped |-> count_reg == DEPTH_C)
        else $error("overflow flagged with room in FIFO");
    a_irq_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> res_reg.irq_inbox_empty != res_reg.irq_inbox_not_empty)
        else $error("interrupt levels disagree");
endmodule

// ===== hw/rtl/coprocessor_mailbox_with_boot_handshake.sv =====
// Coprocessor mailbox with boot handshake. Each transaction (bus read, bus
// write or coprocessor-side message push) is decoded by a front stage, passes
// a two-entry queue and is carried out by a back end sequencer whose states
// are execute, management responder, and FIFO update with result register.
// The sequencer takes one transaction at a time; the front stage and queue
// absorb up to three more while it works. A write to 0x44 boots or stops the
// coprocessor, a send on endpoint 0 is answered autonomously by pushing into
// the 16-entry inbound FIFO, and a push to a full FIFO is dropped with
// overflow_dropped set.
// Depends on cmbx_pkg, cmbx_if, cmbx_front, cmbx_queue and cmbx_back.
module coprocessor_mailbox_with_boot_handshake #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    cmbx_req_if.sink      req,
    cmbx_rsp_if.source    rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import cmbx_pkg::*;

    logic [19:0] base_reg;
    logic [63:0] map_reg [4];
    logic        f_valid;
    logic        f_ready;
    op_t         f_op;
    logic        q_valid;
    logic        q_ready;
    op_t         q_op;
    res_t        r;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers: base at 0x00, map pairs at 0x08 to 0x20.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 20'h08000;
            map_reg[0] <= 64'h51F;
            map_reg[1] <= '0;
            map_reg[2] <= '0;
            map_reg[3] <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[5:3])
                3'd0: base_reg   <= pwdata[19:0];
                3'd1: map_reg[0] <= pwdata;
                3'd2: map_reg[1] <= pwdata;
                3'd3: map_reg[2] <= pwdata;
                3'd4: map_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            3'd0:    prdata = {44'd0, base_reg};
            3'd1:    prdata = map_reg[0];
            3'd2:    prdata = map_reg[1];
            3'd3:    prdata = map_reg[2];
            3'd4:    prdata = map_reg[3];
            default: prdata = '0;
        endcase
    end

    cmbx_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .cmd(req.cmd), .address(req.address),
        .write_data(req.write_data), .endpoint(req.endpoint),
        .base(base_reg),
        .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
    );

    cmbx_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_op(f_op),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_op(q_op)
    );

    cmbx_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
        .map01(map_reg[0]), .map23(map_reg[1]),
        .map45(map_reg[2]), .map67(map_reg[3]),
        .res_valid(rsp.valid), .res_ready(rsp.ready), .res(r)
    );

    assign rsp.read_data           = r.read_data;
    assign rsp.irq_inbox_not_empty = r.irq_inbox_not_empty;
    assign rsp.irq_inbox_empty     = r.irq_inbox_empty;
    assign rsp.overflow_dropped    = r.overflow_dropped;
    assign rsp.message_unhandled   = r.message_unhandled;
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the coprocessor mailbox with boot handshake.
// Depends on cmbx_pkg, cmbx_if and the top level coprocessor_mailbox_with_boot_handshake.
module testbench;
    import cmbx_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 40;

    // One transaction as the sender offers it.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [19:0] address;
        logic [63:0] write_data;
        logic [7:0]  endpoint;
    } bus_txn_t;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cmbx_req_if req_ch ();
    cmbx_rsp_if rsp_ch ();

    coprocessor_mailbox_with_boot_handshake DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted device state. This is the testbench's own copy of the
    // configuration and of everything the device remembers between
    // transactions.
    // ------------------------------------------------------------------
    logic [19:0] win_base;
    logic [63:0] ep_map [4];
    logic [31:0] ctrl_word;
    logic [31:0] status_word;
    logic [31:0] out_ctrl;
    logic [31:0] in_ctrl;
    logic [63:0] staged;
    logic [63:0] inbox_payload [QDEPTH];
    logic [7:0]  inbox_ep [QDEPTH];
    int unsigned inbox_head;
    int unsigned inbox_count;
    logic [1:0]  hs_state;
    logic [15:0] peer_version;
    int unsigned next_map_block;
    logic        pwr_ack_pending;
    logic [15:0] coproc_pwr;
    logic [15:0] host_pwr;
    logic        ep_running [256];
    logic        dropped_now;
    logic        unhandled_now;

    bus_txn_t pending_txns[$];
    res_t     expected_responses[$];

    int  mismatch_count;
    int  cycle_count;
    bit  took_txn;
    int  burst_left;
    int  gap_left;
    int  stall_token;
    int  stall_seen;
    int  stall_left;

    function automatic void inbox_push(logic [7:0] ep, logic [63:0] msg);
        int unsigned idx;
        if (inbox_count >= QDEPTH) begin
            dropped_now = 1'b1;
            return;
        end
        idx = (inbox_head + inbox_count) % QDEPTH;
        inbox_payload[idx] = msg;
        inbox_ep[idx] = ep;
        inbox_count++;
    endfunction

    function automatic void reply(logic [7:0] mtype, logic [63:0] body);
        inbox_push(8'd0, (64'(mtype) << TYPE_SHIFT) | body);
    endfunction

    function automatic logic [31:0] map_word(int unsigned b);
        return ep_map[(b >> 1) & 3][(b & 1) * 32 +: 32];
    endfunction

    // Pages out the next non-empty map block; the last one carries bit 51.
    function automatic void page_map_block();
        int unsigned last_blk;
        int unsigned b;
        logic [63:0] body;
        last_blk = 7;
        while (last_blk > 0 && map_word(last_blk) == 0) last_blk--;
        b = (next_map_block > 7) ? 7 : next_map_block;
        while (b < last_blk && map_word(b) == 0) b++;
        body = (64'(b & 7) << 32) | 64'(map_word(b));
        if (b >= last_blk) body[51] = 1'b1;
        next_map_block = b + 1;
        reply(MT_MAP, body);
    endfunction

    function automatic void start_boot();
        if (hs_state != HS_IDLE) return;
        status_word = 32'd1;
        hs_state = HS_WAIT_ACK;
        reply(MT_HELLO, (64'd12 << 16) | 64'd11);
    endfunction

    function automatic void finish_boot();
        hs_state = HS_BOOTED;
        if (pwr_ack_pending) begin
            pwr_ack_pending = 1'b0;
            coproc_pwr = 16'h20;
            reply(MT_PWR_ACK, 64'h20);
        end
    endfunction

    // Autonomous responder for messages sent on the management endpoint.
    function automatic void answer_mgmt(logic [63:0] msg);
        logic [7:0]  mtype;
        logic [15:0] st;
        mtype = msg[59:52];
        st = msg[15:0];
        case (mtype)
            MT_HELLO_ACK:
            begin
                peer_version = msg[31:16];
                hs_state = HS_WAIT_MAP;
                next_map_block = 0;
                page_map_block();
            end
            MT_MAP:
            begin
                if (msg[51] || !msg[0]) begin
                    if (hs_state == HS_WAIT_MAP) finish_boot();
                end
                else page_map_block();
            end
            MT_PING: reply(MT_PONG, msg & ((64'd1 << TYPE_SHIFT) - 1));
            MT_EP_CTRL: ep_running[msg[39:32]] = (msg[1:0] == 2'd2);
            MT_PWR_REQ:
            begin
                if (st == 16'h220 || st == 16'h20) begin
                    if (hs_state == HS_BOOTED) begin
                        coproc_pwr = 16'h20;
                        reply(MT_PWR_ACK, 64'h20);
                    end
                    else begin
                        pwr_ack_pending = 1'b1;
                        start_boot();
                    end
                end
                else begin
                    coproc_pwr = st;
                    reply(MT_PWR_ACK, 64'(st));
                end
            end
            MT_HOST_PWR:
            begin
                host_pwr = st;
                reply(MT_HOST_PWR, 64'(st));
            end
            default: unhandled_now = 1'b1;
        endcase
    endfunction

    // Computes the response to one accepted transaction and advances the
    // predicted state. The control and status offsets take priority over the
    // mailbox window when the two overlap.
    function automatic res_t mailbox_predict(bus_txn_t t);
        res_t        r;
        logic [63:0] rd;
        logic        in_win;
        logic [11:0] ofs;
        logic        was_run;
        logic        now_run;
        rd = '0;
        dropped_now = 1'b0;
        unhandled_now = 1'b0;
        in_win = (21'(t.address) >= 21'(win_base)) &&
                 (21'(t.address) < 21'(win_base) + 21'h1000);
        ofs = 12'(t.address - win_base);
        if (t.cmd == CMD_READ) begin
            if (t.address == ADDR_CONTROL) rd = 64'(ctrl_word);
            else if (t.address == ADDR_STATUS) rd = 64'(status_word);
            else if (in_win) begin
                case (ofs)
                    OFS_OUT_CTRL: rd = 64'(out_ctrl) | 64'h20000;
                    OFS_IN_CTRL:
                    begin
                        rd = 64'(in_ctrl & ~CTRL_MASK);
                        if (inbox_count == 0) rd[17] = 1'b1;
                        if (inbox_count >= QDEPTH) rd[16] = 1'b1;
                        rd[23:20] = 4'(inbox_count);
                    end
                    OFS_HEAD_PL: if (inbox_count != 0) rd = inbox_payload[inbox_head];
                    OFS_HEAD_EP:
                    begin
                        if (inbox_count != 0) begin
                            rd = 64'(inbox_ep[inbox_head]);
                            inbox_head = (inbox_head + 1) % QDEPTH;
                            inbox_count--;
                        end
                    end
                    OFS_STAGED: rd = staged;
                    default: rd = '0;
                endcase
            end
        end
        else if (t.cmd == CMD_WRITE) begin
            if (t.address == ADDR_CONTROL) begin
                was_run = ctrl_word[4];
                now_run = t.write_data[4];
                ctrl_word = t.write_data[31:0];
                if (now_run && !was_run) start_boot();
                else if (!now_run && was_run) begin
                    // Stopping empties the inbox but leaves its head where it was.
                    status_word = 32'd2;
                    hs_state = HS_IDLE;
                    inbox_count = 0;
                end
            end
            else if (t.address != ADDR_STATUS && in_win) begin
                case (ofs)
                    OFS_OUT_CTRL: out_ctrl = t.write_data[31:0] & ~CTRL_MASK;
                    OFS_IN_CTRL: in_ctrl = t.write_data[31:0] & ~CTRL_MASK;
                    OFS_STAGED: staged = t.write_data;
                    OFS_SEND:
                    begin
                        if (t.write_data[7:0] == 8'd0) answer_mgmt(staged);
                        else unhandled_now = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        else if (t.cmd == CMD_PUSH) inbox_push(t.endpoint, t.write_data);
        r.read_data = rd;
        r.irq_inbox_not_empty = (inbox_count != 0);
        r.irq_inbox_empty = (inbox_count == 0);
        r.overflow_dropped = dropped_now;
        r.message_unhandled = unhandled_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void queue_txn(logic [1:0] cmd, logic [19:0] addr, logic [63:0] data,
                                      logic [7:0] ep);
        bus_txn_t t;
        t.cmd = cmd;
        t.address = addr;
        t.write_data = data;
        t.endpoint = ep;
        pending_txns.push_back(t);
    endfunction

    function automatic logic [19:0] win_addr(logic [11:0] ofs);
        return win_base + 20'(ofs);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Stages a management message and sends it on the given endpoint.
    function automatic void send_msg(logic [63:0] msg, logic [7:0] send_ep);
        queue_txn(CMD_WRITE, win_addr(OFS_STAGED), msg, 8'd0);
        queue_txn(CMD_WRITE, win_addr(OFS_SEND), (rand64() << 8) | 64'(send_ep),
                  8'($urandom()));
    endfunction

    function automatic logic [63:0] random_mgmt_msg();
        logic [63:0] msg;
        logic [7:0]  mtype;
        int          pick;
        msg = rand64();
        pick = $urandom_range(0, 13);
        case (pick)
            0, 1: mtype = MT_HELLO_ACK;
            2, 3, 4: mtype = MT_MAP;
            5: mtype = MT_PING;
            6: mtype = MT_EP_CTRL;
            7, 8: mtype = MT_PWR_REQ;
            9: mtype = MT_HOST_PWR;
            10: mtype = MT_HELLO;
            default: mtype = 8'($urandom());
        endcase
        msg[59:52] = mtype;
        if (mtype == MT_MAP) begin
            // Mostly ask for the next block; sometimes close out the paging.
            msg[0] = ($urandom_range(0, 3) != 0);
            msg[51] = ($urandom_range(0, 5) == 0);
        end
        if (mtype == MT_PWR_REQ && $urandom_range(0, 1))
            msg[15:0] = $urandom_range(0, 1) ? 16'h20 : 16'h220;
        return msg;
    endfunction

    function automatic logic [19:0] noise_addr();
        case ($urandom_range(0, 5))
            0: return 20'($urandom());
            1: return ADDR_CONTROL;
            2: return ADDR_STATUS;
            3: return win_addr(12'($urandom()));
            4: return win_addr({$urandom_range(0, 15) == 0 ? 12'h830 : 12'h110} +
                               12'(4 * $urandom_range(0, 2)));
            default: return win_addr(12'h800 + 12'(8 * $urandom_range(0, 7)));
        endcase
    endfunction

    // Queues one random scenario; the largest share are management message sends,
    // the rest boot or stop the core, drain the inbox, push a message or are noise.
    function automatic void random_scenario();
        int pick;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_msg(random_mgmt_msg(), ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'd0);
        else if (pick < 50) begin
            queue_txn(CMD_WRITE, ADDR_CONTROL,
                      (rand64() & ~64'h1F) |
                      {59'd0, 1'($urandom_range(0, 2) != 0), 4'($urandom())},
                      8'($urandom()));
        end
        else if (pick < 70) begin
            for (i = 0; i < $urandom_range(1, 4); i++) begin
                queue_txn(CMD_READ, win_addr(OFS_HEAD_PL), rand64(), 8'($urandom()));
                queue_txn(CMD_READ, win_addr(OFS_HEAD_EP), rand64(), 8'($urandom()));
            end
            queue_txn(CMD_READ, win_addr(OFS_IN_CTRL), rand64(), 8'($urandom()));
        end
        else if (pick < 80)
            queue_txn(CMD_PUSH, 20'($urandom()), rand64(), 8'($urandom()));
        else queue_txn(2'($urandom()), noise_addr(), rand64(), 8'($urandom()));
    endfunction

    // Writes one configuration register over the APB port; the predictor's
    // copy changes at the same edge as the device's.
    task automatic cfg_write(int unsigned idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(idx * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == 0) win_base = value[19:0];
        else ep_map[idx - 1] = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_txns.size() != 0 || req_ch.valid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!req_ch.valid || took_txn)) begin
            took_txn = 1'b0;
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end
            if (burst_left == 0 && gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_txns.size() != 0) begin
                burst_left--;
                req_ch.valid <= 1'b1;
                {req_ch.cmd, req_ch.address, req_ch.write_data, req_ch.endpoint} <=
                    pending_txns.pop_front();
            end
            else req_ch.valid <= 1'b0;
        end
    end

    // Every accepted transaction is predicted at the edge that accepts it.
    always @(posedge clk) begin
        if (rst_n && req_ch.valid && req_ch.ready) begin
            took_txn = 1'b1;
            expected_responses.push_back(mailbox_predict({req_ch.cmd, req_ch.address,
                                                          req_ch.write_data, req_ch.endpoint}));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: its own random pattern, plus a long hold-off on request.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (stall_token != stall_seen) begin
            stall_seen = stall_token;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (cycle_count % 512 < 128) rsp_ch.ready <= 1'b1;
        else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor: compares each transaction result with the oldest expectation.
    always @(posedge clk) begin
        res_t want;
        res_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.read_data = rsp_ch.read_data;
            got.irq_inbox_not_empty = rsp_ch.irq_inbox_not_empty;
            got.irq_inbox_empty = rsp_ch.irq_inbox_empty;
            got.overflow_dropped = rsp_ch.overflow_dropped;
            got.message_unhandled = rsp_ch.message_unhandled;
            if (expected_responses.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected response read_data=%h", got.read_data);
            end
            else begin
                want = expected_responses.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: response mismatch: expected rd=%h ne=%b e=%b ",
                                  "ovf=%b unh=%b, got rd=%h ne=%b e=%b ovf=%b unh=%b"},
                                 want.read_data, want.irq_inbox_not_empty, want.irq_inbox_empty,
                                 want.overflow_dropped, want.message_unhandled,
                                 got.read_data, got.irq_inbox_not_empty, got.irq_inbox_empty,
                                 got.overflow_dropped, got.message_unhandled);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, a directed pass over the handshake and the
    // inbox corner cases, then random phases under several configurations.
    // ------------------------------------------------------------------
    initial begin
        int phase;
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_READ;
        req_ch.address = '0;
        req_ch.write_data = '0;
        req_ch.endpoint = '0;
        rsp_ch.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        took_txn = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_token = 0;
        stall_seen = 0;
        stall_left = 0;
        win_base = 20'h08000;
        ep_map[0] = 64'h51F;
        ep_map[1] = '0;
        ep_map[2] = '0;
        ep_map[3] = '0;
        ctrl_word = '0;
        status_word = 32'd2;
        out_ctrl = '0;
        in_ctrl = '0;
        staged = '0;
        for (i = 0; i < QDEPTH; i++) begin
            inbox_payload[i] = '0;
            inbox_ep[i] = '0;
        end
        inbox_head = 0;
        inbox_count = 0;
        hs_state = HS_IDLE;
        peer_version = '0;
        next_map_block = 0;
        pwr_ack_pending = 1'b0;
        coproc_pwr = '0;
        host_pwr = '0;
        for (i = 0; i < 256; i++) ep_running[i] = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: power request before boot (pending acknowledgment),
        // hello acknowledgment, map paging to the end, ping with a full body,
        // host power, the unused command, status write, a send of an unknown type
        // on a foreign endpoint, an overflowing inbox and reads of its head.
        send_msg({4'h0, MT_PWR_REQ, 52'h220}, 8'd0);
        send_msg({4'h0, MT_HELLO_ACK, 20'h0, 16'hFFFF, 16'h0}, 8'd0);
        send_msg({4'h0, MT_MAP, 52'h1}, 8'd0);
        send_msg({4'h0, MT_MAP, 52'h8_0000_0000_0000}, 8'd0);
        send_msg({4'hF, MT_PING, 52'hF_FFFF_FFFF_FFFF}, 8'd0);
        send_msg({4'h0, MT_HOST_PWR, 52'hFFFF}, 8'd0);
        send_msg({4'h0, 8'hFF, 52'h0}, 8'hFF);
        queue_txn(CMD_UNUSED, 20'hFFFFF, '1, 8'hFF);
        queue_txn(CMD_WRITE, ADDR_STATUS, '1, 8'h00);
        queue_txn(CMD_READ, ADDR_STATUS, '0, 8'h00);
        queue_txn(CMD_WRITE, win_addr(OFS_IN_CTRL), '1, 8'h00);
        queue_txn(CMD_WRITE, win_addr(OFS_OUT_CTRL), '1, 8'h00);
        queue_txn(CMD_READ, win_addr(OFS_OUT_CTRL), '0, 8'h00);
        for (i = 0; i < 17; i++) queue_txn(CMD_PUSH, 20'(i), (i % 2) ? '1 : '0, 8'(i * 15));
        queue_txn(CMD_READ, win_addr(OFS_IN_CTRL), '0, 8'h00);
        queue_txn(CMD_WRITE, ADDR_CONTROL, 64'h0, 8'h00);
        queue_txn(CMD_READ, win_addr(OFS_HEAD_PL), '0, 8'h00);
        queue_txn(CMD_READ, win_addr(OFS_HEAD_EP), '0, 8'h00);
        wait_drained();

        // Random phases, each after a full round of register writes. Among
        // them are the window at both ends of its range and maps that are
        // all clear or all set.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: cfg_write(0, 64'h08000);
                1: cfg_write(0, 64'h00000);
                2: cfg_write(0, 64'hFF000);
                default: cfg_write(0, 64'($urandom_range(0, 20'hFF000)));
            endcase
            for (i = 1; i <= 4; i++) begin
                case (phase)
                    1: cfg_write(i, '1);
                    2: cfg_write(i, '0);
                    3: cfg_write(i, ($urandom_range(0, 1)) ? rand64() : 64'h0);
                    default: cfg_write(i, i == 1 ? 64'h51F : 64'(1) << $urandom_range(0, 63));
                endcase
            end
            // Each phase begins with a boot and the hello acknowledgment so
            // that the deeper handshake states are reached.
            queue_txn(CMD_WRITE, ADDR_CONTROL, 64'h0, 8'h00);
            queue_txn(CMD_WRITE, ADDR_CONTROL, 64'h10, 8'h00);
            send_msg({4'h0, MT_HELLO_ACK, 52'($urandom()) << 16}, 8'd0);
            while (pending_txns.size() < 300) random_scenario();
            if (phase == 1) begin
                // Hold the receiver off while the sender keeps offering.
                repeat (50) @(posedge clk);
                stall_token++;
            end
            wait_drained();
        end

        if (mismatch_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cmbx_pkg.sv
hw/rtl/cmbx_if.sv
hw/rtl/cmbx_front.sv
hw/rtl/cmbx_queue.sv
hw/rtl/cmbx_back.sv
hw/rtl/coprocessor_mailbox_with_boot_handshake.sv
tb/testbench.sv
